@@ rtl/fsm_min_pkg.sv @@
// Shared constants and types for the state minimizer.
package fsm_min_pkg;

  localparam int MAX_STATES_DEF     = 16;
  localparam int MAX_INPUT_BITS_DEF = 4;
  localparam int OUTPUT_BITS_DEF    = 8;

  // Field widths fixed by the item format.
  localparam int STATE_W   = 4;
  localparam int INPUT_W   = 4;
  localparam int COUNT_W   = 5;
  localparam int IBITS_W   = 3;
  localparam int ROW_OUT_W = 8;

  // Configuration register indexes.
  localparam logic CFG_STATE_COUNT = 1'b0;
  localparam logic CFG_INPUT_BITS  = 1'b1;

  // Actions of an input request.
  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_START = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;        // write one row
    logic clear_pairs; // set all pairs compatible before the output pass
    logic scan_out;    // output comparison phase
    logic scan_next;   // implication phase
    logic rd;          // issue store reads for the current pair and row
    logic mark;        // clear the current pair
    logic rep_step;    // step representative search
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic differ;      // compare result on the registered data of the last read
    logic pair_ok;     // current pair still compatible
    logic rep_hit;     // current candidate is compatible with current state
  } dp_sts_t;

endpackage

@@ rtl/fsm_min_dp.sv @@
// Datapath of the state minimizer: row stores, pair matrix and compares.
module fsm_min_dp #(
  parameter int MAX_STATES     = fsm_min_pkg::MAX_STATES_DEF,
  parameter int MAX_INPUT_BITS = fsm_min_pkg::MAX_INPUT_BITS_DEF,
  parameter int OUTPUT_BITS    = fsm_min_pkg::OUTPUT_BITS_DEF,
  parameter int SW             = $clog2(MAX_STATES),
  parameter int RW             = (MAX_INPUT_BITS > 0) ? MAX_INPUT_BITS : 1
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  fsm_min_pkg::dp_cmd_t              cmd,
  input  logic [SW-1:0]                     idx_i,
  input  logic [SW-1:0]                     idx_j,
  input  logic [RW-1:0]                     row,
  input  logic [SW:0]                       n_use,
  input  logic [fsm_min_pkg::STATE_W-1:0]   ld_state,
  input  logic [fsm_min_pkg::INPUT_W-1:0]   ld_input,
  input  logic [fsm_min_pkg::STATE_W-1:0]   ld_next,
  input  logic [fsm_min_pkg::ROW_OUT_W-1:0] ld_output,
  output fsm_min_pkg::dp_sts_t              sts
);
  import fsm_min_pkg::*;

  localparam int ROWS  = 1 << MAX_INPUT_BITS;
  localparam int DEPTH = MAX_STATES * ROWS;
  localparam int AW    = $clog2(DEPTH);

  // Row stores, two read ports each.
  logic [STATE_W-1:0]     ns_mem [DEPTH];
  logic [OUTPUT_BITS-1:0] out_mem [DEPTH];
  logic [MAX_STATES-1:0]  pair_r [MAX_STATES];

  logic [STATE_W-1:0]     ns_a_r, ns_b_r;
  logic [OUTPUT_BITS-1:0] out_a_r, out_b_r;
  logic                   rd_out_r, rd_next_r;

  logic [AW-1:0] wr_addr, rd_a, rd_b;
  logic [SW+STATE_W:0] st_wide;

  assign st_wide = {{(SW+1){1'b0}}, ld_state};

  // Row address: state in the high bits, input combination below.
  always_comb begin
    if (MAX_INPUT_BITS > 0) begin
      wr_addr = AW'(st_wide * ROWS + (ld_input & INPUT_W'(ROWS - 1)));
    end else begin
      wr_addr = AW'(st_wide);
    end
    rd_a = AW'(idx_i * ROWS + (row & RW'(ROWS - 1)));
    rd_b = AW'(idx_j * ROWS + (row & RW'(ROWS - 1)));
  end

  // Row store write and registered reads.
  always_ff @(posedge clk) begin
    if (cmd.load && (st_wide < (SW+STATE_W+1)'(MAX_STATES))) begin
      ns_mem[wr_addr]  <= ld_next;
      out_mem[wr_addr] <= OUTPUT_BITS'(ld_output);
    end
    ns_a_r  <= ns_mem[rd_a];
    ns_b_r  <= ns_mem[rd_b];
    out_a_r <= out_mem[rd_a];
    out_b_r <= out_mem[rd_b];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_out_r  <= 1'b0;
      rd_next_r <= 1'b0;
    end else begin
      rd_out_r  <= cmd.rd && cmd.scan_out;
      rd_next_r <= cmd.rd && cmd.scan_next;
    end
  end

  // Compatibility of a next-state pair read from the stores.
  logic ns_ok;
  logic [SW:0] na, nb;
  always_comb begin
    na = (SW+1)'(ns_a_r);
    nb = (SW+1)'(ns_b_r);
    if (ns_a_r == ns_b_r) ns_ok = 1'b1;
    else if (na >= n_use || nb >= n_use || na >= (SW+1)'(MAX_STATES)) ns_ok = 1'b0;
    else ns_ok = pair_r[na[SW-1:0]][nb[SW-1:0]];
  end

  assign sts.differ  = (rd_out_r && (out_a_r != out_b_r)) || (rd_next_r && !ns_ok);
  assign sts.pair_ok = pair_r[idx_i][idx_j];
  assign sts.rep_hit = (idx_i == idx_j) || pair_r[idx_i][idx_j];

  // Pair matrix, kept symmetric.
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear_pairs) begin
      for (int k = 0; k < MAX_STATES; k++) pair_r[k] <= '1;
    end else if (cmd.mark) begin
      pair_r[idx_i][idx_j] <= 1'b0;
      pair_r[idx_j][idx_i] <= 1'b0;
    end
  end
endmodule

@@ rtl/fsm_min_ctrl.sv @@
// Controller of the state minimizer: walks pairs, rows and results.
module fsm_min_ctrl #(
  parameter int MAX_STATES     = fsm_min_pkg::MAX_STATES_DEF,
  parameter int MAX_INPUT_BITS = fsm_min_pkg::MAX_INPUT_BITS_DEF,
  parameter int SW             = $clog2(MAX_STATES),
  parameter int RW             = (MAX_INPUT_BITS > 0) ? MAX_INPUT_BITS : 1
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [SW:0]                     n_use,
  input  logic [RW:0]                     rows,
  input  fsm_min_pkg::dp_sts_t            sts,
  input  logic                            res_free,
  output fsm_min_pkg::dp_cmd_t            cmd,
  output logic                            busy,
  output logic [SW-1:0]                   idx_i,
  output logic [SW-1:0]                   idx_j,
  output logic [RW-1:0]                   row,
  output logic                            res_push,
  output logic [fsm_min_pkg::STATE_W-1:0] res_id,
  output logic [fsm_min_pkg::STATE_W-1:0] res_rep,
  output logic                            res_last
);
  import fsm_min_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_PAIR = 3'd1; // choose pair, issue reads
  localparam logic [2:0] ST_ROW  = 3'd2; // one row read per cycle
  localparam logic [2:0] ST_WAIT = 3'd3; // last read result
  localparam logic [2:0] ST_REP  = 3'd4; // representative search
  localparam logic [2:0] ST_INIT = 3'd5;

  logic [2:0]    state_r, state_nxt;
  logic          phase_r, phase_nxt;   // 0 outputs, 1 implications
  logic          chg_r, chg_nxt;
  logic [SW-1:0] i_r, i_nxt, j_r, j_nxt;
  logic [RW:0]   row_r, row_nxt;
  logic          hit_r, hit_nxt;

  assign idx_i = i_r;
  assign idx_j = j_r;
  assign row   = row_r[RW-1:0];
  assign busy  = state_r != ST_IDLE;
  assign res_id   = STATE_W'(j_r);
  assign res_rep  = STATE_W'(i_r);
  assign res_last = (SW+1)'(j_r) + 1'b1 == n_use;

  logic last_pair;
  assign last_pair = ((SW+1)'(j_r) + 1'b1 >= n_use) &&
                     ((SW+1)'(i_r) + 2'd2 >= n_use);

  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    chg_nxt   = chg_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    row_nxt   = row_r;
    hit_nxt   = hit_r;
    cmd       = '0;
    res_push  = 1'b0;
    cmd.scan_out  = !phase_r;
    cmd.scan_next = phase_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.clear_pairs = 1'b1;
          phase_nxt = 1'b0;
          chg_nxt   = 1'b0;
          i_nxt     = '0;
          j_nxt     = SW'(1);
          state_nxt = (n_use > (SW+1)'(1)) ? ST_INIT : ST_REP;
          if (n_use <= (SW+1)'(1)) j_nxt = '0;
        end
      end
      ST_INIT: begin
        row_nxt   = '0;
        hit_nxt   = 1'b0;
        state_nxt = ST_PAIR;
      end
      ST_PAIR: begin
        row_nxt = '0;
        hit_nxt = 1'b0;
        if (phase_r && !sts.pair_ok) begin
          // Already incompatible: skip to next pair.
          state_nxt = ST_WAIT;
          row_nxt   = rows;
        end else begin
          cmd.rd    = 1'b1;
          row_nxt   = (RW+1)'(1);
          state_nxt = (rows == (RW+1)'(1)) ? ST_WAIT : ST_ROW;
        end
      end
      ST_ROW: begin
        if (sts.differ) hit_nxt = 1'b1;
        cmd.rd  = 1'b1;
        row_nxt = row_r + 1'b1;
        if (row_r + 1'b1 == rows) state_nxt = ST_WAIT;
      end
      ST_WAIT: begin
        if (hit_r || sts.differ) begin
          if (!phase_r || sts.pair_ok) begin
            cmd.mark = 1'b1;
            if (phase_r) chg_nxt = 1'b1;
          end
        end
        row_nxt = '0;
        if (last_pair) begin
          i_nxt = '0;
          j_nxt = SW'(1);
          if (!phase_r || chg_r || ((hit_r || sts.differ) && sts.pair_ok)) begin
            phase_nxt = 1'b1;
            chg_nxt   = 1'b0;
            state_nxt = ST_INIT;
          end else begin
            j_nxt     = '0;
            state_nxt = ST_REP;
          end
        end else if ((SW+1)'(j_r) + 1'b1 >= n_use) begin
          i_nxt     = i_r + 1'b1;
          j_nxt     = i_r + SW'(2);
          state_nxt = ST_INIT;
        end else begin
          j_nxt     = j_r + 1'b1;
          state_nxt = ST_INIT;
        end
      end
      ST_REP: begin
        // i_r is the candidate, j_r the state reported.
        cmd.rep_step = 1'b1;
        if (sts.rep_hit) begin
          if (res_free) begin
            res_push = 1'b1;
            i_nxt    = '0;
            j_nxt    = j_r + 1'b1;
            if (res_last) state_nxt = ST_IDLE;
          end
        end else begin
          i_nxt = i_r + 1'b1;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      phase_r <= 1'b0;
      chg_r   <= 1'b0;
      hit_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      chg_r   <= chg_nxt;
      hit_r   <= hit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r   <= i_nxt;
    j_r   <= j_nxt;
    row_r <= row_nxt;
  end
endmodule

@@ rtl/fsm_state_minimizer.sv @@
// Top level of the implication-table state minimizer.
// Load requests are accepted back to back while idle.
// A start request walks the pair matrix: an output pass, then implication
// passes that repeat until stable, then a representative search that
// emits one result per state, held while the output stalls.
// Synchronous active-low reset marks all pairs compatible; row stores are not cleared.
module fsm_state_minimizer #(
  parameter int MAX_STATES     = fsm_min_pkg::MAX_STATES_DEF,
  parameter int MAX_INPUT_BITS = fsm_min_pkg::MAX_INPUT_BITS_DEF,
  parameter int OUTPUT_BITS    = fsm_min_pkg::OUTPUT_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // tdata: row_state[3:0], row_input[7:4], row_next[11:8], row_output[19:12], zero fill
  input  logic [23:0] in_tdata,
  // tuser: action
  input  logic        in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // tdata: state_id[3:0], representative[7:4], kept[8], zero fill
  output logic [15:0] out_tdata,
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data
);
  import fsm_min_pkg::*;

  localparam int SW = $clog2(MAX_STATES);
  localparam int RW = (MAX_INPUT_BITS > 0) ? MAX_INPUT_BITS : 1;

  logic [COUNT_W-1:0] count_r;
  logic [IBITS_W-1:0] ibits_r;
  logic [SW:0]        n_use;
  logic [RW:0]        rows;
  logic [IBITS_W-1:0] bits_eff;

  dp_cmd_t cmd, cmd_dp;
  dp_sts_t sts;
  logic    busy, res_push, res_last, res_free, start, load;
  logic [SW-1:0] idx_i, idx_j;
  logic [RW-1:0] row;
  logic [STATE_W-1:0] res_id, res_rep;

  // Configuration registers.
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= COUNT_W'(16);
      ibits_r <= IBITS_W'(1);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_STATE_COUNT: count_r <= cfg_data[COUNT_W-1:0];
        CFG_INPUT_BITS:  ibits_r <= cfg_data[IBITS_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective state count and row count.
  always_comb begin
    if (count_r == '0) n_use = (SW+1)'(1);
    else if (32'(count_r) > MAX_STATES) n_use = (SW+1)'(MAX_STATES);
    else n_use = (SW+1)'(count_r);
    bits_eff = (32'(ibits_r) > MAX_INPUT_BITS) ? IBITS_W'(MAX_INPUT_BITS) : ibits_r;
    rows = (RW+1)'(1) << bits_eff;
  end

  assign in_tready = !busy;
  assign load  = in_tvalid && in_tready && (in_tuser == ACT_LOAD);
  assign start = in_tvalid && in_tready && (in_tuser == ACT_START);

  always_comb begin
    cmd_dp = cmd;
    cmd_dp.load = load;
  end

  // Output register.
  assign res_free = !out_tvalid || out_tready;
  always_ff @(posedge clk) begin
    if (!rst_n) out_tvalid <= 1'b0;
    else if (res_push) out_tvalid <= 1'b1;
    else if (out_tready) out_tvalid <= 1'b0;
  end
  always_ff @(posedge clk) begin
    if (res_push) begin
      out_tdata <= {7'd0, res_id == res_rep, res_rep, res_id};
      out_tlast <= res_last;
    end
  end

  fsm_min_ctrl #(.MAX_STATES(MAX_STATES), .MAX_INPUT_BITS(MAX_INPUT_BITS)) u_ctrl (
    .clk, .rst_n, .start, .n_use, .rows, .sts, .res_free, .cmd, .busy,
    .idx_i, .idx_j, .row, .res_push, .res_id, .res_rep, .res_last
  );

  fsm_min_dp #(.MAX_STATES(MAX_STATES), .MAX_INPUT_BITS(MAX_INPUT_BITS),
               .OUTPUT_BITS(OUTPUT_BITS)) u_dp (
    .clk, .rst_n, .cmd(cmd_dp), .idx_i, .idx_j, .row, .n_use,
    .ld_state(in_tdata[3:0]), .ld_input(in_tdata[7:4]),
    .ld_next(in_tdata[11:8]), .ld_output(in_tdata[19:12]), .sts
  );

  // A result is never pushed over one that has not been taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> res_free) else $error("result overwritten");
  // No input request is accepted while the matrix is being walked.
  a_idle_accept: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !in_tready) else $error("accepted while busy");
  // A reported representative never exceeds its state.
  a_rep_order: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> res_rep <= res_id) else $error("bad representative");
endmodule
